// ===== design/sff_pkg.sv =====
// ----------------------------------------------------------------------------
// sff_pkg: shared types and constants of the stereo frame FIFO
// Holds the command word passed from front to back and the constants of the
// divide-by-100 volume scaling pipeline.
// ----------------------------------------------------------------------------
package sff_pkg;

    // Command word produced by the front end for every taken item
    typedef struct packed {
        logic accepted;  // push stored, or pop found a frame
        logic underrun;  // pop found the ring empty
        logic scale;     // word carries a frame that must be volume scaled
    } sff_cmd_t;

    localparam int CMD_W = $bits(sff_cmd_t);

    // floor(2^32 / 100): quotient estimate is exact or one short
    localparam logic [25:0] RECIP_100   = 26'd42949672;
    localparam int          RECIP_SHIFT = 32;

    // (x * 5243) >> 19 == x / 100 for every x below 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Register stages of one scaling lane
    localparam int LANE_STAGES = 6;

endpackage

// ===== design/stereo_frame_fifo_with_volume.sv =====
// ----------------------------------------------------------------------------
// stereo_frame_fifo_with_volume: ring FIFO of stereo frames with volume
// Path: a word taken passes the front registers, the command queue, the
//   scaling pipeline and the output queue before it shows on the result ports.
// Throughput: one word per cycle, push or pop, while full is low; set by the
//   one frame store access per word at the front; scaling lanes fully pipelined.
// Reset: pointers cleared, volume set to 80, queues emptied; the frame store
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module stereo_frame_fifo_with_volume
    import sff_pkg::*;
#(
    parameter int FIFO_DEPTH  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input side
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic                          accepted,
    output logic                          underrun,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Depth of the command queue between front and back, and of the
    // result queue; the result queue covers the scaling pipeline.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int MCW       = $clog2(MID_DEPTH+1);
    localparam int MID_W     = CMD_W + 2*SAMPLE_BITS;

    // Register index 0 at byte address 0: volume in percent
    localparam logic       REG_VOLUME    = 1'b0;
    localparam logic [6:0] VOLUME_RESET  = 7'd80;

    logic [6:0]       volume_reg;
    logic             cfg_write;
    logic             mid_push, mid_pop;
    logic [MID_W-1:0] mid_in, mid_out;
    logic [MCW-1:0]   mid_count;

    // ------------------------------------------------------------------
    // Configuration: zero-wait writes, register decoded on the word address
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= VOLUME_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_VOLUME))
        begin
            volume_reg <= pwdata[6:0];
        end
    end

    // Unmapped addresses read as zero
    assign prdata = (paddr[2] == REG_VOLUME) ? {25'd0, volume_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Front: classify each word, move the ring pointers, access the store
    // ------------------------------------------------------------------
    sff_front #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MID_DEPTH   (MID_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .left_in   (left_in),
        .right_in  (right_in),
        .mid_count (mid_count),
        .mid_push  (mid_push),
        .mid_data  (mid_in)
    );

    // ------------------------------------------------------------------
    // Command queue: decouples store access from scaling
    // ------------------------------------------------------------------
    sff_queue #(.DEPTH(MID_DEPTH), .WIDTH(MID_W)) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_in),
        .pop   (mid_pop),
        .dout  (mid_out),
        .count (mid_count)
    );

    // ------------------------------------------------------------------
    // Back: scale popped frames and hold results until taken
    // ------------------------------------------------------------------
    sff_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MID_DEPTH   (MID_DEPTH),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .volume    (volume_reg),
        .mid_count (mid_count),
        .mid_data  (mid_out),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .accepted  (accepted),
        .underrun  (underrun),
        .left_out  (left_out),
        .right_out (right_out)
    );

`ifndef SYNTHESIS
    // Credit accounting keeps the command queue from overflowing
    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (mid_count < MCW'(MID_DEPTH)) || mid_pop)
        else $error("command queue pushed while full");

    // Back end never pops an empty command queue
    a_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> mid_count != '0)
        else $error("command queue popped while empty");

    // A volume write lands in the register
    a_volume_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (paddr[2] == REG_VOLUME)) |=> volume_reg == $past(pwdata[6:0]))
        else $error("volume register write lost");

    // Results never claim both a taken frame and an underrun
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(accepted && underrun))
        else $error("result flags accepted and underrun both set");
`endif

endmodule

// ===== design/sff_queue.sv =====
// ----------------------------------------------------------------------------
// sff_queue: small register-based first-in first-out queue
// Head word is shown combinationally; push and pop may happen together.
// ----------------------------------------------------------------------------
module sff_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
        step = (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        head_next  = pop  ? step(head_reg) : head_reg;
        tail_next  = push ? step(tail_reg) : tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= din;
        end
    end

    assign dout  = slot_reg[head_reg];
    assign count = count_reg;

endmodule

// ===== design/sff_front.sv =====
// ----------------------------------------------------------------------------
// sff_front: ring pointers, frame store and item classification
// Accepts push/pop items, writes or reads the frame store and hands a
// command word with the read frame to the command queue.
// ----------------------------------------------------------------------------
module sff_front
    import sff_pkg::*;
#(
    parameter int FIFO_DEPTH  = 8192,
    parameter int SAMPLE_BITS = 24,
    parameter int MID_DEPTH   = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                mode,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    input  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count,
    output logic                                mid_push,
    output logic [CMD_W+2*SAMPLE_BITS-1:0]      mid_data
);

    localparam int   AW        = $clog2(FIFO_DEPTH);
    localparam int   MCW       = $clog2(MID_DEPTH+1);
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    logic [AW-1:0]            wp_reg, wp_next;
    logic [AW-1:0]            rp_reg, rp_next;
    logic [AW-1:0]            wp_adv, rp_adv;
    logic                     a_valid_reg;
    sff_cmd_t                 a_cmd_reg;
    sff_cmd_t                 cmd;
    logic [2*SAMPLE_BITS-1:0] store_mem [FIFO_DEPTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic                     take;
    logic                     ring_full, ring_empty;
    logic                     wr_en, rd_en;

    // Credits: items in the command queue plus the one in flight
    assign full = ((MCW+1)'(mid_count) + (MCW+1)'(a_valid_reg)) >= (MCW+1)'(MID_DEPTH);
    assign take = push && !full;

    assign wp_adv     = (wp_reg == AW'(FIFO_DEPTH-1)) ? '0 : wp_reg + AW'(1);
    assign rp_adv     = (rp_reg == AW'(FIFO_DEPTH-1)) ? '0 : rp_reg + AW'(1);
    assign ring_full  = (wp_adv == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);

    assign wr_en = take && (mode == MODE_PUSH) && !ring_full;
    assign rd_en = take && (mode == MODE_POP) && !ring_empty;

    always_comb
    begin
        cmd.accepted = wr_en || rd_en;
        cmd.underrun = take && (mode == MODE_POP) && ring_empty;
        cmd.scale    = rd_en;
        wp_next      = wr_en ? wp_adv : wp_reg;
        rp_next      = rd_en ? rp_adv : rp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            a_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        a_cmd_reg <= cmd;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wp_reg] <= {left_in, right_in};
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rp_reg];
        end
    end

    assign mid_push = a_valid_reg;
    assign mid_data = {a_cmd_reg, rd_data_reg};

endmodule

// ===== design/sff_scale.sv =====
// ----------------------------------------------------------------------------
// sff_scale: one volume scaling lane
// Computes sample * volume / 100 truncated toward zero and saturated, in a
// free-running six-stage pipeline on sign and magnitude.
// ----------------------------------------------------------------------------
module sff_scale
    import sff_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [6:0]                    volume,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + 26;
    localparam int QW     = SB - 6;
    localparam int TW     = QW + 7;
    localparam int MW     = SB + 2;

    localparam logic [SB-1:0] HUNDRED   = SB'(100);
    localparam logic [MW-1:0] POS_LIMIT = MW'((64'd1 << (SB-1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIMIT = MW'(64'd1 << (SB-1));
    localparam logic [SB-1:0] NEG_MIN   = {1'b1, {(SB-1){1'b0}}};

    // stage 1: sign and magnitude
    logic          neg1_reg;
    logic [SB-1:0] mag1_reg;
    logic [6:0]    vol1_reg;
    // stage 2: reciprocal product
    logic              neg2_reg;
    logic [SB-1:0]     mag2_reg;
    logic [6:0]        vol2_reg;
    logic [PROD_W-1:0] prod2_reg;
    // stage 3: magnitude split into quotient and remainder by 100
    logic          neg3_reg;
    logic [QW-1:0] q3_reg;
    logic [6:0]    r3_reg;
    logic [6:0]    vol3_reg;
    // stage 4: partial products with volume
    logic          neg4_reg;
    logic [TW-1:0] t4_reg;
    logic [13:0]   u4_reg;
    // stage 5: scaled magnitude
    logic          neg5_reg;
    logic [MW-1:0] mag5_reg;
    // stage 6: signed, saturated result
    logic [SB-1:0] res6_reg;

    logic [QW-1:0] q0;
    logic [SB-1:0] r0;
    logic          fix;
    logic [26:0]   uprod;
    logic [7:0]    uq;
    logic [SB-1:0] res_next;

    always_comb
    begin
        q0    = prod2_reg[PROD_W-1:RECIP_SHIFT];
        r0    = mag2_reg - SB'(q0) * HUNDRED;
        fix   = (r0 >= HUNDRED);
        uprod = 27'(u4_reg) * 27'(DIV100_MUL);
        uq    = uprod[DIV100_SHIFT+7:DIV100_SHIFT];
        if (!neg5_reg)
        begin
            res_next = (mag5_reg > POS_LIMIT) ? POS_LIMIT[SB-1:0] : mag5_reg[SB-1:0];
        end
        else
        begin
            res_next = (mag5_reg > NEG_LIMIT) ? NEG_MIN : (~mag5_reg[SB-1:0] + SB'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= sample_in[SB-1];
        mag1_reg  <= sample_in[SB-1] ? (~$unsigned(sample_in) + SB'(1)) : $unsigned(sample_in);
        vol1_reg  <= volume;

        neg2_reg  <= neg1_reg;
        mag2_reg  <= mag1_reg;
        vol2_reg  <= vol1_reg;
        prod2_reg <= PROD_W'(mag1_reg) * PROD_W'(RECIP_100);

        neg3_reg  <= neg2_reg;
        q3_reg    <= fix ? q0 + QW'(1) : q0;
        r3_reg    <= fix ? 7'(r0 - HUNDRED) : 7'(r0);
        vol3_reg  <= vol2_reg;

        neg4_reg  <= neg3_reg;
        t4_reg    <= TW'(q3_reg) * TW'(vol3_reg);
        u4_reg    <= 14'(r3_reg) * 14'(vol3_reg);

        neg5_reg  <= neg4_reg;
        mag5_reg  <= MW'(t4_reg) + MW'(uq);

        res6_reg  <= res_next;
    end

    assign sample_out = $signed(res6_reg);

endmodule

// ===== design/sff_back.sv =====
// ----------------------------------------------------------------------------
// sff_back: execution side of the stereo frame FIFO
// Drains the command queue through two scaling lanes and collects result
// words in an output queue; admits a command only when it has room.
// ----------------------------------------------------------------------------
module sff_back
    import sff_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MID_DEPTH   = 4,
    parameter int OUT_DEPTH   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [6:0]                          volume,
    input  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count,
    input  logic [CMD_W+2*SAMPLE_BITS-1:0]      mid_data,
    output logic                                mid_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic                                accepted,
    output logic                                underrun,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out
);

    localparam int SB  = SAMPLE_BITS;
    localparam int OCW = $clog2(OUT_DEPTH+1);
    localparam int IFW = $clog2(LANE_STAGES+1);
    localparam int OW  = CMD_W + 2*SB;

    logic [LANE_STAGES-1:0] vld_reg;
    sff_cmd_t               cmd_pipe_reg [LANE_STAGES];
    sff_cmd_t               mid_cmd, out_cmd, res_cmd;
    logic signed [SB-1:0]   mid_left, mid_right;
    logic signed [SB-1:0]   lane_left, lane_right;
    logic [IFW-1:0]         inflight;
    logic [OCW-1:0]         out_count;
    logic [OW-1:0]          out_din, out_dout;
    logic                   out_pop;

    assign {mid_cmd, mid_left, mid_right} = mid_data;

    // Admit a command only if its result is sure to find a slot
    assign inflight = IFW'($countones(vld_reg));
    assign mid_pop  = (mid_count != '0) &&
                      (((OCW+1)'(out_count) + (OCW+1)'(inflight)) < (OCW+1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LANE_STAGES-2:0], mid_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_pipe_reg[0] <= mid_cmd;
        for (int i = 1; i < LANE_STAGES; i++)
        begin
            cmd_pipe_reg[i] <= cmd_pipe_reg[i-1];
        end
    end

    sff_scale #(.SAMPLE_BITS(SB)) u_scale_left (
        .clk        (clk),
        .sample_in  (mid_left),
        .volume     (volume),
        .sample_out (lane_left)
    );

    sff_scale #(.SAMPLE_BITS(SB)) u_scale_right (
        .clk        (clk),
        .sample_in  (mid_right),
        .volume     (volume),
        .sample_out (lane_right)
    );

    // Drop lane data for words that carry no frame
    assign out_cmd = cmd_pipe_reg[LANE_STAGES-1];
    assign out_din = {out_cmd,
                      out_cmd.scale ? lane_left  : SB'(0),
                      out_cmd.scale ? lane_right : SB'(0)};

    sff_queue #(.DEPTH(OUT_DEPTH), .WIDTH(OW)) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (vld_reg[LANE_STAGES-1]),
        .din   (out_din),
        .pop   (out_pop),
        .dout  (out_dout),
        .count (out_count)
    );

    assign empty   = (out_count == '0);
    assign out_pop = pop && !empty;

    assign {res_cmd, left_out, right_out} = out_dout;
    assign accepted = res_cmd.accepted;
    assign underrun = res_cmd.underrun;

endmodule

// ===== tb/sv/stereo_ring_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_ring_check_pkg: expected-result tracking for the stereo frame FIFO
// Mirrors the ring pointers, the frame store and the volume register, works
// out the result of every accepted input word and checks output words in order.
// ----------------------------------------------------------------------------
package stereo_ring_check_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int SAMPLE_W   = 24;

    localparam longint SAMPLE_MAX = longint'(2 ** (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } frame_op_e;

    typedef struct {
        logic                       accepted;
        logic                       underrun;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_result_t;

    class stereo_ring_tracker;
        logic signed [SAMPLE_W-1:0] left_mem  [RING_DEPTH];
        logic signed [SAMPLE_W-1:0] right_mem [RING_DEPTH];
        int unsigned                wr_ptr;
        int unsigned                rd_ptr;
        bit [6:0]                   volume_pct;
        frame_result_t              awaited_outputs [$];
        int                         errors;

        function new();
            wr_ptr     = 0;
            rd_ptr     = 0;
            volume_pct = 7'd80;
            errors     = 0;
        endfunction

        // Frames currently held in the ring
        function int unsigned held();
            return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction

        // Truncate toward zero, then clip to the sample range
        function logic signed [SAMPLE_W-1:0] apply_volume(logic signed [SAMPLE_W-1:0] s);
            longint prod;
            prod = (longint'(s) * longint'(volume_pct)) / 100;
            if (prod > SAMPLE_MAX)
                prod = SAMPLE_MAX;
            if (prod < SAMPLE_MIN)
                prod = SAMPLE_MIN;
            return prod[SAMPLE_W-1:0];
        endfunction

        function void take_input_word(frame_op_e op, logic signed [SAMPLE_W-1:0] l,
                                      logic signed [SAMPLE_W-1:0] r);
            frame_result_t res;
            int unsigned   nxt;
            res = '{accepted: 1'b0, underrun: 1'b0, left: '0, right: '0};
            if (op == MODE_PUSH)
            begin
                nxt = (wr_ptr + 1) % RING_DEPTH;
                if (nxt != rd_ptr)
                begin
                    left_mem[wr_ptr]  = l;
                    right_mem[wr_ptr] = r;
                    wr_ptr            = nxt;
                    res.accepted      = 1'b1;
                end
            end
            else if (rd_ptr == wr_ptr)
            begin
                res.underrun = 1'b1;
            end
            else
            begin
                res.left     = apply_volume(left_mem[rd_ptr]);
                res.right    = apply_volume(right_mem[rd_ptr]);
                rd_ptr       = (rd_ptr + 1) % RING_DEPTH;
                res.accepted = 1'b1;
            end
            awaited_outputs.push_back(res);
        endfunction

        function void check_output_word(logic acc, logic und,
                                        logic signed [SAMPLE_W-1:0] l,
                                        logic signed [SAMPLE_W-1:0] r);
            frame_result_t want;
            if (awaited_outputs.size() == 0)
            begin
                $error("output word arrived with nothing awaited");
                errors++;
                return;
            end
            want = awaited_outputs.pop_front();
            if (acc !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, acc);
                errors++;
            end
            if (und !== want.underrun)
            begin
                $error("underrun: expected %0d, got %0d", want.underrun, und);
                errors++;
            end
            if (l !== want.left)
            begin
                $error("left_out: expected %0d, got %0d", want.left, l);
                errors++;
            end
            if (r !== want.right)
            begin
                $error("right_out: expected %0d, got %0d", want.right, r);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_stereo_frame_fifo_with_volume.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_frame_fifo_with_volume: self-checking bench for the stereo FIFO
// Drives push and pop words through the queue handshake and the volume
// register through the APB port, tracks the ring in a scoreboard and checks
// every output word in order. A directed opener hits the sample extremes,
// empty pops and saturating gains; random phases then vary the idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_stereo_frame_fifo_with_volume;
    import stereo_ring_check_pkg::*;

    localparam logic [2:0] VOLUME_ADDR   = 3'd0;
    // Settling wait after the last awaited output word; leave margin
    localparam int         DRAIN_CYCLES  = 16;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         PHASE_WORDS   = 630;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       empty;
    logic                       pop = 1'b0;
    logic                       accepted;
    logic                       underrun;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    stereo_ring_tracker sb;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 readback_errors;
    longint             cycle_count;

    stereo_frame_fifo_with_volume #(
        .FIFO_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .left_in   (left_in),
        .right_in  (right_in),
        .empty     (empty),
        .pop       (pop),
        .accepted  (accepted),
        .underrun  (underrun),
        .left_out  (left_out),
        .right_out (right_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost output word ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: check the word taken at this edge, then pick next cycle's
    // pop. Values read here are the pre-edge ones, so no ordering race.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_output_word(accepted, underrun, left_out, right_out);
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Mostly random codes, with the extremes and small magnitudes weighted up
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_TOP;
            1:       return SAMPLE_BOTTOM;
            2:       return SAMPLE_W'($urandom_range(255));
            3:       return SAMPLE_W'(-int'($urandom_range(255)));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Present one word and hold it until the block takes it; push stays high
    // so a back-to-back word needs no second assignment in the same step.
    task automatic send_word(frame_op_e op, logic signed [SAMPLE_W-1:0] l,
                             logic signed [SAMPLE_W-1:0] r);
        push     <= 1'b1;
        mode     <= op;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.take_input_word(op, l, r);
    endtask

    // Random sender gaps between words
    task automatic hold_gap();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every awaited word, plus a DRAIN_CYCLES margin
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_volume(int unsigned pct);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VOLUME_ADDR;
        pwdata  <= 32'(pct);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.volume_pct = pct[6:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_volume_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= VOLUME_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(sb.volume_pct))
        begin
            $error("volume: expected %0d, got %0d", sb.volume_pct, prdata);
            readback_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Change the gain only with the block drained
    task automatic change_gain(int unsigned pct);
        wait_idle();
        write_volume(pct);
        check_volume_readback();
    endtask

    // Random mix of pushes and pops; halfway through, pause until drained
    task automatic run_random(int n);
        frame_op_e op;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_idle();
            hold_gap();
            op = ($urandom_range(99) < 48) ? MODE_POP : MODE_PUSH;
            send_word(op, pick_sample(), pick_sample());
        end
    endtask

    initial
    begin
        int tx_plan [3];
        int rx_plan [3];
        int vol_plan [3];

        sb              = new();
        readback_errors = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rst_n           = 1'b0;
        push            = 1'b0;
        mode            = MODE_PUSH;
        left_in         = '0;
        right_in        = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = VOLUME_ADDR;
        pwdata          = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gain is 80
        check_volume_readback();

        // Directed: empty pop, sample extremes at the reset gain
        send_word(MODE_POP, SAMPLE_TOP, SAMPLE_BOTTOM);
        send_word(MODE_PUSH, SAMPLE_TOP, SAMPLE_BOTTOM);
        send_word(MODE_PUSH, SAMPLE_BOTTOM, SAMPLE_TOP);
        send_word(MODE_PUSH, '0, -1);
        send_word(MODE_PUSH, 1, -SAMPLE_TOP);
        repeat (5) send_word(MODE_POP, '0, '0);

        // Gain above 100 saturates at both ends
        change_gain(127);
        send_word(MODE_PUSH, SAMPLE_TOP, SAMPLE_BOTTOM);
        send_word(MODE_PUSH, -100, 100);
        send_word(MODE_POP, '0, '0);
        send_word(MODE_POP, '0, '0);

        // Zero gain gives silence on a real frame
        change_gain(0);
        send_word(MODE_PUSH, SAMPLE_TOP, SAMPLE_BOTTOM);
        send_word(MODE_POP, '0, '0);

        // Just above unity
        change_gain(101);
        send_word(MODE_PUSH, SAMPLE_BOTTOM, SAMPLE_TOP);
        send_word(MODE_POP, '0, '0);

        // Random phases: receiver-heavy idling, sender-heavy idling, none
        tx_plan  = '{33, 47, 0};
        rx_plan  = '{47, 33, 0};
        vol_plan = '{100, $urandom_range(2, 99), 127};
        for (int p = 0; p < 3; p++)
        begin
            change_gain(vol_plan[p]);
            tx_idle_pct = tx_plan[p];
            rx_idle_pct = rx_plan[p];
            run_random(PHASE_WORDS);
        end

        wait_idle();
        if (sb.errors == 0 && readback_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
